/* src/slcf_pkg.sv */
// ----------------------------------------------------------------------------
// slcf_pkg
// Types and constants shared by the serial link connection framer modules.
// ----------------------------------------------------------------------------
package slcf_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SIZE_RAW_W  = 7;
    localparam int AGE_W       = 17;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_ROLE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_SIZE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TX_SIZE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TX_PERIOD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE = 3'd5;

    localparam logic ROLE_MASTER = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_RX   = 2'd1,
        OP_PAY  = 2'd2,
        OP_READ = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_TX     = 2'd1,
        KIND_FRAME  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        LINK_DISC = 2'd0,
        LINK_WAIT = 2'd1,
        LINK_CONN = 2'd2
    } link_t;

    typedef enum logic [1:0] {
        SEL_RES_A = 2'd0,
        SEL_RES_B = 2'd1,
        SEL_FRAME = 2'd2
    } sel_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_EXEC    = 3'd1,
        S_COPY_RD = 3'd2,
        S_COPY_WR = 3'd3,
        S_EMIT_A  = 3'd4,
        S_EMIT_B  = 3'd5,
        S_READ_RD = 3'd6,
        S_READ_OUT = 3'd7
    } ctrl_state_t;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic idx_clr;
        logic idx_inc;
        logic stg_rd;
        logic rdy_wr;
        logic rdy_rd;
        logic load_out;
        sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic copy_req;
        logic read_req;
        logic two;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* src/slcf_ram.sv */
// ----------------------------------------------------------------------------
// slcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/slcf_ctrl.sv */
// ----------------------------------------------------------------------------
// slcf_ctrl
// Sequencer: accepts an item, runs the step, sweeps frame copies and read
// bursts, and loads results into the output register.
// ----------------------------------------------------------------------------
module slcf_ctrl
    import slcf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.copy_req)
                begin
                    state_next = S_COPY_RD;
                end
                else if (stat.read_req)
                begin
                    state_next = S_READ_RD;
                end
                else
                begin
                    state_next = S_EMIT_A;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                state_next = stat.idx_last ? S_EMIT_A : S_COPY_RD;
            end
            S_EMIT_A:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.two ? S_EMIT_B : S_IDLE;
                end
            end
            S_EMIT_B:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ_RD:
            begin
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.idx_last ? S_IDLE : S_READ_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready   = 1'b0;
        cmd          = '0;
        cmd.out_sel  = SEL_RES_A;
        case (state_reg)
            S_IDLE:
            begin
                item_ready   = 1'b1;
                cmd.latch_in = item_valid;
            end
            S_EXEC:
            begin
                cmd.exec    = 1'b1;
                cmd.idx_clr = 1'b1;
            end
            S_COPY_RD:
            begin
                cmd.stg_rd = 1'b1;
            end
            S_COPY_WR:
            begin
                cmd.rdy_wr  = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_EMIT_A:
            begin
                cmd.load_out = stat.out_free;
                cmd.out_sel  = SEL_RES_A;
            end
            S_EMIT_B:
            begin
                cmd.load_out = stat.out_free;
                cmd.out_sel  = SEL_RES_B;
            end
            S_READ_RD:
            begin
                cmd.rdy_rd = 1'b1;
            end
            S_READ_OUT:
            begin
                cmd.load_out = stat.out_free;
                cmd.out_sel  = SEL_FRAME;
                cmd.idx_inc  = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* src/slcf_dp.sv */
// ----------------------------------------------------------------------------
// slcf_dp
// Datapath: configuration registers, link state, checksums, age counters,
// staging and ready frame buffers, and the output register.
// ----------------------------------------------------------------------------
module slcf_dp
    import slcf_pkg::*;
#(
    parameter int FRAME_MAX = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]             op,
    input  logic [7:0]             data_byte,
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat,
    input  logic                   result_ready,
    output logic                   result_valid,
    output logic [1:0]             kind,
    output logic [7:0]             out_byte,
    output logic                   last,
    output logic                   connected,
    output logic                   should_send,
    output logic                   frame_available,
    output logic [1:0]             link_state
);

    localparam int POS_W  = $clog2(FRAME_MAX);
    localparam int SIZE_W = $clog2(FRAME_MAX + 1);
    localparam int CMP_W  = (SIZE_W > SIZE_RAW_W) ? SIZE_W : SIZE_RAW_W;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_RAW_W-1:0] raw);
        logic [CMP_W-1:0] r;
        logic [CMP_W-1:0] c;
        begin
            r = CMP_W'(raw);
            if (r < CMP_W'(2))
            begin
                c = CMP_W'(2);
            end
            else if (r > CMP_W'(FRAME_MAX))
            begin
                c = CMP_W'(FRAME_MAX);
            end
            else
            begin
                c = r;
            end
            clamp_size = SIZE_W'(c);
        end
    endfunction

    // configuration
    logic                  role_reg;
    logic [SIZE_RAW_W-1:0] rx_size_cfg_reg;
    logic [SIZE_RAW_W-1:0] tx_size_cfg_reg;
    logic [15:0]           rx_timeout_reg;
    logic [15:0]           tx_period_reg;
    logic [7:0]            start_code_reg;

    // link state
    link_t            link_reg, link_next;
    logic             listen_reg, listen_next;
    logic [7:0]       start_byte_reg, start_byte_next;
    logic [POS_W-1:0] rx_pos_reg, rx_pos_next;
    logic [7:0]       rx_sum_reg, rx_sum_next;
    logic             avail_reg, avail_next;
    logic [AGE_W-1:0] rx_age_reg, rx_age_next;
    logic [AGE_W-1:0] tx_age_reg, tx_age_next;
    logic [POS_W-1:0] tx_pos_reg, tx_pos_next;
    logic [7:0]       tx_sum_reg, tx_sum_next;

    // step payload and pending results
    logic [1:0]       op_reg;
    logic [7:0]       data_reg;
    kind_t            res_kind_reg, res_kind_next;
    logic [7:0]       res_byte_reg, res_byte_next;
    logic             res_two_reg, res_two_next;
    logic [7:0]       res_chk_reg, res_chk_next;
    logic [POS_W-1:0] idx_reg, idx_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       out_conn_reg, out_conn_next;
    logic       out_send_reg, out_send_next;
    logic       out_avail_reg, out_avail_next;
    logic [1:0] out_link_reg, out_link_next;

    logic [SIZE_W-1:0] rx_size;
    logic [SIZE_W-1:0] tx_size;
    logic [AGE_W-1:0]  rx_age_inc;
    logic [AGE_W-1:0]  tx_age_inc;
    logic [7:0]        rx_weight;
    logic [7:0]        tx_weight;
    logic [7:0]        rx_sum_add;
    logic [7:0]        tx_sum_add;
    logic [POS_W-1:0]  tx_pos_inc;
    logic              rx_at_end;
    logic              tx_at_end;
    logic              rx_in_frame;
    logic              rx_timed_out;
    logic              conn_now;
    logic              send_now;

    logic             stg_wr_en;
    logic [POS_W-1:0] stg_wr_addr;
    logic [7:0]       stg_rd_data;
    logic [7:0]       rdy_rd_data;

    assign rx_size      = clamp_size(rx_size_cfg_reg);
    assign tx_size      = clamp_size(tx_size_cfg_reg);
    assign rx_age_inc   = (rx_age_reg == AGE_MAX) ? AGE_MAX : rx_age_reg + AGE_W'(1);
    assign tx_age_inc   = (tx_age_reg == AGE_MAX) ? AGE_MAX : tx_age_reg + AGE_W'(1);
    assign rx_timed_out = rx_age_inc > AGE_W'(rx_timeout_reg);
    assign rx_weight    = 8'(SIZE_W'(rx_pos_reg) + SIZE_W'(1));
    assign tx_weight    = 8'(SIZE_W'(tx_pos_reg) + SIZE_W'(1));
    assign rx_sum_add   = rx_sum_reg + 8'(data_reg * rx_weight);
    assign tx_sum_add   = tx_sum_reg + 8'(data_reg * tx_weight);
    assign tx_pos_inc   = tx_pos_reg + POS_W'(1);
    assign rx_at_end    = (SIZE_W'(rx_pos_reg) + SIZE_W'(1)) >= rx_size;
    assign tx_at_end    = (SIZE_W'(tx_pos_inc) + SIZE_W'(1)) >= tx_size;
    assign rx_in_frame  = (link_reg != LINK_DISC) && !listen_reg;
    assign conn_now     = (link_reg == LINK_CONN);
    assign send_now     = conn_now && (tx_age_reg >= AGE_W'(tx_period_reg));

    assign stat.copy_req = (op_t'(op_reg) == OP_RX) && rx_in_frame && rx_at_end
                           && (data_reg == rx_sum_reg);
    assign stat.read_req = (op_t'(op_reg) == OP_READ) && conn_now && avail_reg;
    assign stat.two      = res_two_reg;
    assign stat.idx_last = (SIZE_W'(idx_reg) == (rx_size - SIZE_W'(1)));
    assign stat.out_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg        <= ROLE_MASTER;
            rx_size_cfg_reg <= SIZE_RAW_W'(8);
            tx_size_cfg_reg <= SIZE_RAW_W'(8);
            rx_timeout_reg  <= 16'd100;
            tx_period_reg   <= 16'd20;
            start_code_reg  <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROLE:       role_reg        <= cfg_data[0];
                CFG_RX_SIZE:    rx_size_cfg_reg <= cfg_data[SIZE_RAW_W-1:0];
                CFG_TX_SIZE:    tx_size_cfg_reg <= cfg_data[SIZE_RAW_W-1:0];
                CFG_RX_TIMEOUT: rx_timeout_reg  <= cfg_data;
                CFG_TX_PERIOD:  tx_period_reg   <= cfg_data;
                CFG_START_CODE: start_code_reg  <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // step
    always_comb
    begin
        link_next       = link_reg;
        listen_next     = listen_reg;
        start_byte_next = start_byte_reg;
        rx_pos_next     = rx_pos_reg;
        rx_sum_next     = rx_sum_reg;
        avail_next      = avail_reg;
        rx_age_next     = rx_age_reg;
        tx_age_next     = tx_age_reg;
        tx_pos_next     = tx_pos_reg;
        tx_sum_next     = tx_sum_reg;
        res_kind_next   = res_kind_reg;
        res_byte_next   = res_byte_reg;
        res_two_next    = res_two_reg;
        res_chk_next    = res_chk_reg;
        stg_wr_en       = 1'b0;
        stg_wr_addr     = rx_pos_reg;
        if (cmd.exec)
        begin
            res_kind_next = KIND_STATUS;
            res_byte_next = 8'd0;
            res_two_next  = 1'b0;
            case (op_t'(op_reg))
                OP_TICK:
                begin
                    rx_age_next = rx_age_inc;
                    tx_age_next = tx_age_inc;
                    case (link_reg)
                        LINK_DISC:
                        begin
                            avail_next  = 1'b0;
                            rx_age_next = '0;
                            tx_age_next = '0;
                            rx_pos_next = '0;
                            rx_sum_next = 8'd0;
                            tx_pos_next = '0;
                            tx_sum_next = 8'd0;
                            if (role_reg == ROLE_MASTER)
                            begin
                                listen_next     = 1'b0;
                                start_byte_next = start_code_reg;
                                res_kind_next   = KIND_TX;
                                res_byte_next   = start_code_reg;
                            end
                            else
                            begin
                                start_byte_next = 8'd0;
                                listen_next     = 1'b1;
                            end
                            link_next = LINK_WAIT;
                        end
                        LINK_WAIT:
                        begin
                            if (avail_reg)
                            begin
                                if (role_reg == ROLE_MASTER)
                                begin
                                    listen_next = 1'b0;
                                    link_next   = LINK_CONN;
                                end
                                else
                                begin
                                    avail_next = 1'b0;
                                    if (start_byte_reg == start_code_reg)
                                    begin
                                        listen_next = 1'b0;
                                        rx_pos_next = '0;
                                        rx_sum_next = 8'd0;
                                        tx_age_next = AGE_MAX;
                                        link_next   = LINK_CONN;
                                    end
                                end
                            end
                            else if (rx_timed_out)
                            begin
                                link_next   = LINK_DISC;
                                listen_next = 1'b0;
                                rx_pos_next = '0;
                                rx_sum_next = 8'd0;
                            end
                        end
                        default:
                        begin
                            if (rx_timed_out)
                            begin
                                link_next   = LINK_DISC;
                                listen_next = 1'b0;
                                rx_pos_next = '0;
                                rx_sum_next = 8'd0;
                            end
                        end
                    endcase
                end
                OP_RX:
                begin
                    if (link_reg != LINK_DISC)
                    begin
                        if (listen_reg)
                        begin
                            start_byte_next = data_reg;
                            avail_next      = 1'b1;
                            rx_age_next     = '0;
                        end
                        else if (rx_at_end)
                        begin
                            stg_wr_en   = 1'b1;
                            stg_wr_addr = POS_W'(rx_size - SIZE_W'(1));
                            if (data_reg == rx_sum_reg)
                            begin
                                avail_next  = 1'b1;
                                rx_age_next = '0;
                            end
                            rx_pos_next = '0;
                            rx_sum_next = 8'd0;
                        end
                        else
                        begin
                            stg_wr_en   = 1'b1;
                            rx_sum_next = rx_sum_add;
                            rx_pos_next = rx_pos_reg + POS_W'(1);
                        end
                    end
                end
                OP_PAY:
                begin
                    if (conn_now)
                    begin
                        res_kind_next = KIND_TX;
                        res_byte_next = data_reg;
                        if (tx_at_end)
                        begin
                            res_two_next = 1'b1;
                            res_chk_next = tx_sum_add;
                            tx_pos_next  = '0;
                            tx_sum_next  = 8'd0;
                            tx_age_next  = '0;
                        end
                        else
                        begin
                            tx_pos_next = tx_pos_inc;
                            tx_sum_next = tx_sum_add;
                        end
                    end
                end
                default:
                begin
                    if (conn_now && avail_reg)
                    begin
                        avail_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + POS_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_conn_next  = out_conn_reg;
        out_send_next  = out_send_reg;
        out_avail_next = out_avail_reg;
        out_link_next  = out_link_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_conn_next  = conn_now;
            out_send_next  = send_now;
            out_avail_next = avail_reg;
            out_link_next  = link_reg;
            case (cmd.out_sel)
                SEL_RES_B:
                begin
                    out_kind_next = KIND_TX;
                    out_byte_next = res_chk_reg;
                    out_last_next = 1'b1;
                end
                SEL_FRAME:
                begin
                    out_kind_next = KIND_FRAME;
                    out_byte_next = rdy_rd_data;
                    out_last_next = stat.idx_last;
                end
                default:
                begin
                    out_kind_next = res_kind_reg;
                    out_byte_next = res_byte_reg;
                    out_last_next = !res_two_reg;
                end
            endcase
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg       <= LINK_DISC;
            listen_reg     <= 1'b0;
            start_byte_reg <= 8'd0;
            rx_pos_reg     <= '0;
            rx_sum_reg     <= 8'd0;
            avail_reg      <= 1'b0;
            rx_age_reg     <= '0;
            tx_age_reg     <= '0;
            tx_pos_reg     <= '0;
            tx_sum_reg     <= 8'd0;
            idx_reg        <= '0;
            res_two_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            link_reg       <= link_next;
            listen_reg     <= listen_next;
            start_byte_reg <= start_byte_next;
            rx_pos_reg     <= rx_pos_next;
            rx_sum_reg     <= rx_sum_next;
            avail_reg      <= avail_next;
            rx_age_reg     <= rx_age_next;
            tx_age_reg     <= tx_age_next;
            tx_pos_reg     <= tx_pos_next;
            tx_sum_reg     <= tx_sum_next;
            idx_reg        <= idx_next;
            res_two_reg    <= res_two_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= op;
            data_reg <= data_byte;
        end
        res_kind_reg  <= res_kind_next;
        res_byte_reg  <= res_byte_next;
        res_chk_reg   <= res_chk_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_conn_reg  <= out_conn_next;
        out_send_reg  <= out_send_next;
        out_avail_reg <= out_avail_next;
        out_link_reg  <= out_link_next;
    end

    slcf_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_MAX)
    ) u_staging (
        .clk     (clk),
        .wr_en   (stg_wr_en),
        .wr_addr (stg_wr_addr),
        .wr_data (data_reg),
        .rd_en   (cmd.stg_rd),
        .rd_addr (idx_reg),
        .rd_data (stg_rd_data)
    );

    slcf_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_MAX)
    ) u_ready (
        .clk     (clk),
        .wr_en   (cmd.rdy_wr),
        .wr_addr (idx_reg),
        .wr_data (stg_rd_data),
        .rd_en   (cmd.rdy_rd),
        .rd_addr (idx_reg),
        .rd_data (rdy_rd_data)
    );

    assign result_valid    = out_valid_reg;
    assign kind            = out_kind_reg;
    assign out_byte        = out_byte_reg;
    assign last            = out_last_reg;
    assign connected       = out_conn_reg;
    assign should_send     = out_send_reg;
    assign frame_available = out_avail_reg;
    assign link_state      = out_link_reg;

endmodule

/* src/serial_link_connection_framer_top.sv */
// ----------------------------------------------------------------------------
// serial_link_connection_framer_top
// Master/slave serial link framer with checksummed fixed-size frames.
//
// Items enter on the item channel (op, data_byte) under valid/ready; results
// leave on the result channel, one transfer per result, last marking the
// final result of an item. Registers are written through the cfg channel,
// which is always ready; write them only while the block is idle.
// A tick, a dropped byte or a status-only step goes through the execute and
// emit states to the output register, a second result through a further emit
// state. With a receiver that keeps up, the next item after a single-result
// item is taken once the sequencer is back in idle. A received checksum byte
// that matches copies the frame from the staging buffer to the ready buffer,
// each byte through a staging read and a ready write state. A read emits
// rx_frame_size bytes, each through a read state on the ready buffer's
// registered read port and an output state. A new item is taken while the
// last result still waits in the output register; a stalled receiver holds the
// sequencer once a further result is due. Reset leaves the link disconnected
// with nothing pending; frame buffers hold no defined contents until written.
// ----------------------------------------------------------------------------
module serial_link_connection_framer_top
    import slcf_pkg::*;
#(
    parameter int FRAME_MAX = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [1:0]             op,
    input  logic [7:0]             data_byte,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [1:0]             kind,
    output logic [7:0]             out_byte,
    output logic                   last,
    output logic                   connected,
    output logic                   should_send,
    output logic                   frame_available,
    output logic [1:0]             link_state
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    slcf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    slcf_dp #(
        .FRAME_MAX (FRAME_MAX)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .op              (op),
        .data_byte       (data_byte),
        .cmd             (cmd),
        .stat            (stat),
        .result_ready    (result_ready),
        .result_valid    (result_valid),
        .kind            (kind),
        .out_byte        (out_byte),
        .last            (last),
        .connected       (connected),
        .should_send     (should_send),
        .frame_available (frame_available),
        .link_state      (link_state)
    );

    a_conn_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (connected == (link_state == LINK_CONN)))
        else $error("connected disagrees with link_state");

    a_send_needs_conn: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && should_send) |-> connected)
        else $error("should_send raised while not connected");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_STATUS) |-> (last && out_byte == 8'd0))
        else $error("status result not final or carries a byte");

    a_frame_needs_conn: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_FRAME) |-> (connected && !frame_available))
        else $error("frame byte emitted outside a connected read");

endmodule
